[src/ipv4hc_pkg.sv]
// Package for the IPv4 header checker: verdict codes, field widths,
// the queue item carried from front to back, and the default queue depth.
// No dependencies.
package ipv4hc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  // Byte positions inside the header
  localparam logic [15:0] POS_TTL        = 16'd8;
  localparam logic [15:0] POS_DEST_FIRST = 16'd16;
  localparam logic [15:0] POS_DEST_LAST  = 16'd19;

  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_VERSION = 3'd1,
    V_HDRLEN  = 3'd2,
    V_TTL     = 3'd3,
    V_DEST    = 3'd4,
    V_SUM     = 3'd5,
    V_TRUNC   = 3'd6
  } verdict_t;

  // One classified byte, from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        first;     // byte 0: version and IHL
    logic        ttl;       // TTL byte
    logic        dest;      // one of the destination bytes
    logic        odd;       // second byte of a 16-bit word
    logic        near;      // position below 64
    logic [5:0]  pos_lo;    // low bits of the position
    logic [15:0] total;     // saturated count including this byte
  } item_t;

endpackage

[src/ipv4hc_front.sv]
// Front part of the IPv4 header checker: counts bytes and tags each one
// with its role in the header. Depends on ipv4hc_pkg.
module ipv4hc_front import ipv4hc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output item_t       item
);

  logic [15:0] count;

  // Saturating byte position, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (last_byte) begin
        count <= '0;
      end else if (count != COUNT_MAX) begin
        count <= count + 16'd1;
      end
    end
  end

  // Classify the byte by position
  always_comb begin
    item.data   = data_byte;
    item.last   = last_byte;
    item.first  = (count == '0);
    item.ttl    = (count == POS_TTL);
    item.dest   = (count >= POS_DEST_FIRST) && (count <= POS_DEST_LAST);
    item.odd    = count[0];
    item.near   = (count[15:6] == '0);
    item.pos_lo = count[5:0];
    item.total  = (count == COUNT_MAX) ? COUNT_MAX : count + 16'd1;
  end

endmodule

[src/ipv4hc_queue.sv]
// Short FIFO of classified bytes between front and back.
// Depends on ipv4hc_pkg.
module ipv4hc_queue import ipv4hc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CW'(DEPTH)) else $error("queue pushed while full");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue level did not grow on push");

endmodule

[src/ipv4hc_back.sv]
// Back part of the IPv4 header checker: header fields, ones'-complement
// sum, verdict and output register. Depends on ipv4hc_pkg.
module ipv4hc_back import ipv4hc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] local_address,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        take,
  output logic        m_valid,
  input  logic        m_ready,
  output verdict_t    m_verdict,
  output logic [15:0] m_length
);

  logic [7:0]  version_ihl_byte, version_ihl_byte_next;
  logic        ttl_is_zero, ttl_is_zero_next;
  logic [31:0] dest_shift, dest_shift_next;
  logic [15:0] sum_acc, sum_acc_next;
  logic [7:0]  high_half, high_half_next;
  logic [16:0] sum_raw;
  logic [3:0]  ihl;
  logic [5:0]  hdr_bytes;
  logic        out_free;
  verdict_t    verdict;

  assign out_free = !m_valid || m_ready;
  assign take     = q_valid && (!q_item.last || out_free);

  // Per-packet field updates for the byte at the queue head
  always_comb begin
    version_ihl_byte_next = q_item.first ? q_item.data : version_ihl_byte;
    ttl_is_zero_next      = q_item.ttl ? (q_item.data == '0) : ttl_is_zero;
    dest_shift_next       = q_item.dest ? {dest_shift[23:0], q_item.data} : dest_shift;
    ihl                   = version_ihl_byte_next[3:0];
    hdr_bytes             = {ihl, 2'b00};
    high_half_next        = q_item.odd ? high_half : q_item.data;
    sum_raw               = {1'b0, sum_acc} + {1'b0, high_half, q_item.data};
    sum_acc_next          = sum_acc;
    if (q_item.odd && q_item.near && (q_item.pos_lo < hdr_bytes)) begin
      sum_acc_next = sum_raw[15:0] + {15'b0, sum_raw[16]};
    end
  end

  // Verdict, in check priority
  always_comb begin
    priority if (version_ihl_byte_next[7:4] != IP_VERSION) begin
      verdict = V_VERSION;
    end else if (ihl < IHL_MIN) begin
      verdict = V_HDRLEN;
    end else if (q_item.total < {10'b0, hdr_bytes}) begin
      verdict = V_TRUNC;
    end else if (ttl_is_zero_next) begin
      verdict = V_TTL;
    end else if (dest_shift_next != BROADCAST_ADDR && dest_shift_next != local_address) begin
      verdict = V_DEST;
    end else if (sum_acc_next != SUM_GOOD) begin
      verdict = V_SUM;
    end else begin
      verdict = V_ACCEPT;
    end
  end

  // Packet state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      version_ihl_byte <= '0;
      ttl_is_zero      <= 1'b0;
      dest_shift       <= '0;
      sum_acc          <= '0;
      high_half        <= '0;
    end else if (take) begin
      if (q_item.last) begin
        version_ihl_byte <= '0;
        ttl_is_zero      <= 1'b0;
        dest_shift       <= '0;
        sum_acc          <= '0;
        high_half        <= '0;
      end else begin
        version_ihl_byte <= version_ihl_byte_next;
        ttl_is_zero      <= ttl_is_zero_next;
        dest_shift       <= dest_shift_next;
        sum_acc          <= sum_acc_next;
        high_half        <= high_half_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (take && q_item.last) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.last) begin
      m_verdict <= verdict;
      m_length  <= q_item.total;
    end
  end

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    take && q_item.last |=> m_valid && m_length == $past(q_item.total))
    else $error("final byte gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_valid && !m_ready |-> !(take && q_item.last))
    else $error("pending result overwritten");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    take && q_item.last |=> sum_acc == '0 && version_ihl_byte == '0)
    else $error("packet state not cleared");

endmodule

[src/ipv4_header_checker.sv]
// Top level of the IPv4 header checker: byte front end, item queue and
// checking back end. Depends on ipv4hc_pkg, ipv4hc_front, ipv4hc_queue, ipv4hc_back.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    s_tdata[7:0] data_byte, s_tlast last_byte
//   m_*       out        m_tvalid/m_tready    m_tdata[2:0] verdict, [18:3] packet_length
//   config    in         local_address_wr     local_address[31:0]
//
// One byte is taken per cycle while s_tready is high; the result of a packet passes
// from its final byte through the queue entry, then the output register.
// The back end handles one byte per cycle unless a final byte waits on a stalled
// result, and adds a 16-bit word on each odd header byte.
// Reset clears the byte counter, the queue, all packet state and the output.
// A stalled result holds the back end only at a final byte; the queue absorbs
// QUEUE_DEPTH bytes before s_tready drops.
module ipv4_header_checker import ipv4hc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        local_address_wr,
  input  logic [31:0] local_address,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] verdict, [18:3] packet_length, [23:19] zero
);

  logic        accept;
  item_t       front_item;
  item_t       head_item;
  logic        q_not_empty;
  logic        take;
  logic [31:0] local_addr_reg;
  verdict_t    verdict;
  logic [15:0] packet_length;

  assign accept  = s_tvalid && s_tready;
  assign m_tdata = {5'b0, packet_length, verdict};

  // Local address register
  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr_reg <= '0;
    end else if (local_address_wr) begin
      local_addr_reg <= local_address;
    end
  end

  ipv4hc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .item      (front_item)
  );

  ipv4hc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .not_full  (s_tready),
    .pop       (take),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  ipv4hc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .local_address (local_addr_reg),
    .q_valid       (q_not_empty),
    .q_item        (head_item),
    .take          (take),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .m_verdict     (verdict),
    .m_length      (packet_length)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for ipv4_header_checker: streams packets byte by byte,
// predicts each verdict and length in step with the stream, and checks every result.
// Depends on ipv4hc_pkg and the RTL under src/.
module testbench;
  import ipv4hc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct {
    verdict_t    verdict;
    logic [15:0] length;
  } packet_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        local_address_wr = 1'b0;
  logic [31:0] local_address = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] data_byte
  logic        s_tlast = 1'b0; // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [2:0] verdict, [18:3] packet_length, [23:19] zero

  // Bytes waiting to be sent and packet results still to come
  stream_byte_t   byte_queue[$];
  packet_result_t pending_verdicts[$];

  // Predicted per-packet state and the address copy
  logic [15:0] byte_pos = '0;
  logic [7:0]  first_byte = '0;
  logic        ttl_zero = 1'b0;
  logic [31:0] dest_word = '0;
  logic [15:0] hdr_sum = '0;
  logic [7:0]  word_hi = '0;
  logic [31:0] my_addr = '0;

  logic s_fire = 1'b0;
  bit   quiet = 1'b0;
  int   fail_count = 0;
  int   results_seen = 0;
  int   bytes_added = 0;
  int   packets_added = 0;

  // Sender and receiver pacing
  int send_gap = 0;
  int send_mode_left = 0;
  bit send_busy = 1'b1;
  int recv_gap = 0;
  int recv_mode_left = 0;
  bit recv_busy = 1'b1;
  int hold_left = 0;
  bit hold_done = 1'b0;

  ipv4_header_checker dut (
    .clk              (clk),
    .rst              (rst),
    .local_address_wr (local_address_wr),
    .local_address    (local_address),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[15:0]} + s[16];
    return s[15:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Update the predicted packet state with one byte; a final byte yields a verdict
  task automatic classify_byte(input logic [7:0] b, input logic last);
    logic [15:0]    idx;
    logic [5:0]     hdr_len;
    packet_result_t r;
    idx = byte_pos;
    if (idx == 16'd0) first_byte = b;
    if (idx == POS_TTL) ttl_zero = (b == 8'd0);
    if (idx >= POS_DEST_FIRST && idx <= POS_DEST_LAST) dest_word = {dest_word[23:0], b};
    hdr_len = {first_byte[3:0], 2'b00};
    if (!idx[0]) begin
      word_hi = b;
    end else if (idx < {10'd0, hdr_len}) begin
      hdr_sum = ones_add(hdr_sum, {word_hi, b});
    end
    if (byte_pos != COUNT_MAX) byte_pos++;
    if (last) begin
      if (first_byte[7:4] != IP_VERSION) r.verdict = V_VERSION;
      else if (first_byte[3:0] < IHL_MIN) r.verdict = V_HDRLEN;
      else if (byte_pos < {10'd0, hdr_len}) r.verdict = V_TRUNC;
      else if (ttl_zero) r.verdict = V_TTL;
      else if (dest_word != BROADCAST_ADDR && dest_word != my_addr) r.verdict = V_DEST;
      else if (hdr_sum != SUM_GOOD) r.verdict = V_SUM;
      else r.verdict = V_ACCEPT;
      r.length = byte_pos;
      pending_verdicts.push_back(r);
      byte_pos = '0;
      first_byte = '0;
      ttl_zero = 1'b0;
      dest_word = '0;
      hdr_sum = '0;
      word_hi = '0;
    end
  endtask

  // Build one packet: header fields, optional valid checksum, optional damage
  task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] ttl, input logic [31:0] dest,
                              input bit seal, input bit damage, input int n);
    logic [7:0]  pkt[];
    logic [15:0] acc;
    logic [15:0] len;
    int          hdr;
    int          k;
    pkt = new[n];
    for (k = 0; k < n; k++) pkt[k] = 8'($urandom);
    hdr = ihl * 4;
    len = 16'(n);
    pkt[0] = {ver, ihl};
    if (n > 3) begin
      pkt[2] = len[15:8];
      pkt[3] = len[7:0];
    end
    if (n > 8) pkt[8] = ttl;
    for (k = 16; k < 20 && k < n; k++) pkt[k] = dest[8 * (19 - k) +: 8];
    if (seal && hdr >= 12 && n >= hdr) begin
      pkt[10] = 8'd0;
      pkt[11] = 8'd0;
      acc = '0;
      for (k = 0; k < hdr; k += 2) acc = ones_add(acc, {pkt[k], pkt[k + 1]});
      acc = ~acc;
      pkt[10] = acc[15:8];
      pkt[11] = acc[7:0];
    end
    if (damage && n > 7) pkt[$urandom_range(4, 7)] ^= (8'h01 << $urandom_range(0, 7));
    for (k = 0; k < n; k++) byte_queue.push_back('{data: pkt[k], last: (k == n - 1)});
    bytes_added += n;
    packets_added++;
  endtask

  task automatic queue_fill(input logic [7:0] value, input int n);
    int k;
    for (k = 0; k < n; k++) byte_queue.push_back('{data: value, last: (k == n - 1)});
    bytes_added += n;
    packets_added++;
  endtask

  // Mostly well-formed headers with random content; the rest carry one fault or random fields
  task automatic queue_random_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [31:0] dest;
    bit          seal;
    bit          damage;
    int          n;
    ver = IP_VERSION;
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : IHL_MIN;
    ttl = 8'($urandom_range(1, 255));
    dest = $urandom_range(0, 1) ? BROADCAST_ADDR : my_addr;
    seal = 1'b1;
    damage = 1'b0;
    n = ((ihl < IHL_MIN) ? 20 : ihl * 4) + $urandom_range(0, 8);
    if ($urandom_range(0, 9) >= 7) begin
      case ($urandom_range(0, 6))
        0: ver = 4'($urandom);
        1: begin
          ihl = 4'($urandom_range(0, 4));
          n = 20 + $urandom_range(0, 8);
        end
        2: ttl = 8'd0;
        3: dest = $urandom;
        4: damage = 1'b1;
        5: n = $urandom_range(1, ihl * 4 - 1);
        default: begin
          ver = 4'($urandom);
          ihl = 4'($urandom);
          ttl = 8'($urandom);
          dest = $urandom;
          seal = 1'($urandom_range(0, 1));
          n = $urandom_range(1, 40);
        end
      endcase
    end
    queue_packet(ver, ihl, ttl, dest, seal, damage, n);
  endtask

  task automatic write_local_address(input logic [31:0] value);
    @(negedge clk);
    local_address_wr <= 1'b1;
    local_address <= value;
    @(negedge clk);
    local_address_wr <= 1'b0;
    my_addr = value;
  endtask

  // Wait until every byte is sent and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (byte_queue.size() != 0 || s_tvalid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random_phase();
    bytes_added = 0;
    packets_added = 0;
    while (bytes_added < 90 || packets_added < 3) queue_random_packet();
    wait_drained();
  endtask

  // Byte accepted: feed the predictor
  always @(posedge clk) begin
    s_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) classify_byte(s_tdata, s_tlast);
  end

  // Result accepted: compare with the oldest prediction
  always @(posedge clk) begin : check_results
    packet_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, verdict", m_tdata[2:0], -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[2:0] != want.verdict)
          report_mismatch("verdict", m_tdata[2:0], want.verdict);
        if (m_tdata[18:3] != want.length)
          report_mismatch("packet_length", m_tdata[18:3], want.length);
      end
    end
  end

  // Byte driver: holds an item until taken, random gaps between items
  always @(negedge clk) begin : drive_bytes
    logic       nv;
    logic [7:0] nd;
    logic       nl;
    nv = 1'b0;
    nd = s_tdata;
    nl = s_tlast;
    if (send_mode_left == 0) begin
      send_mode_left = $urandom_range(20, 80);
      send_busy = ($urandom_range(0, 2) != 0);
    end else begin
      send_mode_left--;
    end
    if (!rst) begin
      if (s_fire) void'(byte_queue.pop_front());
      nv = s_tvalid && !s_fire;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_queue.size() != 0) begin
          if (!quiet && send_busy && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(0, 3);
          end else begin
            nv = 1'b1;
            nd = byte_queue[0].data;
            nl = byte_queue[0].last;
          end
        end
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
    s_tlast <= nl;
  end

  // Result receiver: random stalls plus one long hold-off under traffic
  always @(negedge clk) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (recv_mode_left == 0) begin
      recv_mode_left = $urandom_range(20, 80);
      recv_busy = ($urandom_range(0, 2) != 0);
    end else begin
      recv_mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && results_seen >= 10 && byte_queue.size() > 40) begin
      hold_done = 1'b1;
      hold_left = 149;
      rdy = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else if (!quiet && recv_busy && $urandom_range(0, 3) == 0) begin
      recv_gap = $urandom_range(0, 3);
      rdy = 1'b0;
    end
    m_tready <= rdy;
  end

  // Main sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets: each check, priorities, extremes
    write_local_address($urandom);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, 4'd15, 8'd255, BROADCAST_ADDR, 1'b1, 1'b0, 80);
    queue_packet(4'd0, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(4'd15, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(4'd6, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, 4'd0, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, 4'd4, 8'd64, my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd0, my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, ~my_addr, 1'b1, 1'b0, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b1, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, my_addr, 1'b0, 1'b0, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 19);
    queue_packet(IP_VERSION, 4'd15, 8'd64, my_addr, 1'b1, 1'b0, 59);
    queue_packet(IP_VERSION, IHL_MIN, 8'd64, my_addr, 1'b1, 1'b0, 1);
    queue_packet(IP_VERSION, 4'd6, 8'd0, 32'd0, 1'b1, 1'b0, 24);
    queue_packet(4'd0, 4'd0, 8'd0, 32'd0, 1'b0, 1'b0, 20);
    queue_packet(IP_VERSION, IHL_MIN, 8'd0, 32'd0, 1'b1, 1'b0, 10);
    queue_packet(IP_VERSION, 4'd15, 8'd1, BROADCAST_ADDR, 1'b1, 1'b0, 61);
    queue_fill(8'hFF, 21);
    queue_fill(8'h00, 21);
    wait_drained();

    // Random traffic under several address settings
    write_local_address(32'h0000_0000);
    run_random_phase();
    write_local_address(32'hFFFF_FFFF);
    run_random_phase();
    write_local_address($urandom);
    run_random_phase();

    // Last stretch runs without idling on either side
    quiet = 1'b1;
    run_random_phase();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
